// ===== rtl/core/bu4c_pkg.sv =====
package bu4c_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SOURCE_WIDTH = 2'd0,
    CFG_WINDOW_TOP   = 2'd1,
    CFG_WINDOW_LEFT  = 2'd2
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SRC_WIDTH_W = 11;
  localparam int unsigned WIN_POS_W   = 10;
  localparam int unsigned SRC_Y_W     = 10;
  localparam int unsigned COORD_W     = 9;
  localparam int unsigned OUT_DATA_W  = 32;

  localparam logic [SRC_WIDTH_W-1:0] RESET_SOURCE_WIDTH = 11'd512;

  // Depth of the cell queue between the front and the back end.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  // The four corner pixels of one 2x2 cell.
  typedef struct packed {
    logic [PIX_W-1:0] a;  // upper left
    logic [PIX_W-1:0] b;  // upper right
    logic [PIX_W-1:0] c;  // lower left
    logic [PIX_W-1:0] d;  // lower right
  } corners_t;

  // Marks a cell on the last window row or column, which also emits the edge copies.
  typedef struct packed {
    logic last_row;
    logic last_col;
  } edge_t;

endpackage

// ===== rtl/core/bu4c_fifo.sv =====
module bu4c_fifo #(
  parameter int unsigned WIDTH = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wvalid_i,
  output logic             wready_o,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             rvalid_o,
  input  logic             rready_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = bu4c_pkg::FIFO_PTR_W;

  logic [WIDTH-1:0] mem_q [bu4c_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PW:0]      count_q, count_d;
  logic             push, pop;

  assign wready_o = (count_q != (PW+1)'(bu4c_pkg::FIFO_DEPTH));
  assign rvalid_o = (count_q != '0);
  assign rdata_o  = mem_q[rd_ptr_q];
  assign push     = wvalid_i && wready_o;
  assign pop      = rvalid_o && rready_i;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/bu4c_front.sv =====
module bu4c_front #(
  parameter int unsigned WINDOW_SIZE      = 128,
  parameter int unsigned MAX_SOURCE_WIDTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bu4c_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bu4c_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  pix_valid_i,
  output logic                                  pix_ready_o,
  input  logic [bu4c_pkg::PIX_W-1:0]            pix_value_i,
  input  logic                                  frame_start_i,
  output logic                                  cmd_valid_o,
  input  logic                                  cmd_ready_i,
  output bu4c_pkg::corners_t                    cmd_corners_o,
  output logic [$clog2(WINDOW_SIZE)-1:0]        cmd_row_o,
  output logic [$clog2(WINDOW_SIZE)-1:0]        cmd_col_o,
  output bu4c_pkg::edge_t                       cmd_edge_o
);

  localparam int unsigned WW  = $clog2(WINDOW_SIZE);
  localparam int unsigned XW  = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned PW0 = (XW > bu4c_pkg::SRC_WIDTH_W) ? XW : bu4c_pkg::SRC_WIDTH_W;
  localparam int unsigned PW  = PW0 + 1;
  localparam int unsigned YW  = bu4c_pkg::SRC_Y_W;

  logic [bu4c_pkg::SRC_WIDTH_W-1:0] src_width_q;
  logic [bu4c_pkg::WIN_POS_W-1:0]   win_top_q, win_left_q;
  logic [XW-1:0]                    src_x_q, src_x_d, cur_x;
  logic [YW-1:0]                    src_y_q, src_y_d, cur_y;
  logic [PW-1:0]                    x_ext, y_ext, dx, dy, sw_ext, lim_w, nx;
  logic                             in_win, accept;
  logic [WW-1:0]                    wx, wy;

  logic [bu4c_pkg::PIX_W-1:0]       lb_mem [WINDOW_SIZE];
  logic [bu4c_pkg::PIX_W-1:0]       lb_rd_q;

  logic                             s1_vld_q, s1_win_q;
  logic [bu4c_pkg::PIX_W-1:0]       s1_pix_q;
  logic [WW-1:0]                    s1_wx_q, s1_wy_q;
  logic [bu4c_pkg::PIX_W-1:0]       ul_q, left_q;
  logic                             emit, fire;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q <= bu4c_pkg::RESET_SOURCE_WIDTH;
      win_top_q   <= '0;
      win_left_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bu4c_pkg::CFG_SOURCE_WIDTH: src_width_q <= cfg_data_i;
        bu4c_pkg::CFG_WINDOW_TOP:   win_top_q   <= cfg_data_i[bu4c_pkg::WIN_POS_W-1:0];
        bu4c_pkg::CFG_WINDOW_LEFT:  win_left_q  <= cfg_data_i[bu4c_pkg::WIN_POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Source position of this request and its place in the crop window.
  always_comb begin
    cur_x  = frame_start_i ? '0 : src_x_q;
    cur_y  = frame_start_i ? '0 : src_y_q;
    x_ext  = PW'(cur_x);
    y_ext  = PW'(cur_y);
    dx     = x_ext - PW'(win_left_q);
    dy     = y_ext - PW'(win_top_q);
    in_win = (x_ext >= PW'(win_left_q)) && (y_ext >= PW'(win_top_q)) &&
             (dx < PW'(WINDOW_SIZE)) && (dy < PW'(WINDOW_SIZE));
    wx     = dx[WW-1:0];
    wy     = dy[WW-1:0];
  end

  // Row wrap, with the programmed width clamped to a usable range.
  always_comb begin
    sw_ext = PW'(src_width_q);
    if (sw_ext > PW'(MAX_SOURCE_WIDTH)) begin
      lim_w = PW'(MAX_SOURCE_WIDTH);
    end else if (sw_ext == '0) begin
      lim_w = PW'(1);
    end else begin
      lim_w = sw_ext;
    end
    nx = x_ext + PW'(1);
    if (nx >= lim_w) begin
      src_x_d = '0;
      src_y_d = cur_y + 1'b1;
    end else begin
      src_x_d = nx[XW-1:0];
      src_y_d = cur_y;
    end
  end

  assign accept = pix_valid_i && pix_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_x_q <= '0;
      src_y_q <= '0;
    end else if (accept) begin
      src_x_q <= src_x_d;
      src_y_q <= src_y_d;
    end
  end

  // Line buffer: the pixel above is read while the new one takes its place.
  always_ff @(posedge clk_i) begin
    if (accept && in_win) begin
      lb_mem[wx] <= pix_value_i;
      lb_rd_q    <= lb_mem[wx];
    end
  end

  // Second stage: a pixel that closes a cell hands the cell to the queue.
  assign emit        = s1_win_q && (s1_wy_q != '0) && (s1_wx_q != '0);
  assign fire        = s1_vld_q && (!emit || cmd_ready_i);
  assign pix_ready_o = !s1_vld_q || fire;
  assign cmd_valid_o = s1_vld_q && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_win_q <= 1'b0;
    end else if (pix_ready_o) begin
      s1_vld_q <= pix_valid_i;
      s1_win_q <= in_win;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pix_value_i;
      s1_wx_q  <= wx;
      s1_wy_q  <= wy;
    end
  end

  // Left and upper-left neighbors follow the window pixels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q   <= '0;
      left_q <= '0;
    end else if (fire && s1_win_q) begin
      ul_q   <= lb_rd_q;
      left_q <= s1_pix_q;
    end
  end

  assign cmd_corners_o.a     = ul_q;
  assign cmd_corners_o.b     = lb_rd_q;
  assign cmd_corners_o.c     = left_q;
  assign cmd_corners_o.d     = s1_pix_q;
  assign cmd_row_o           = s1_wy_q - 1'b1;
  assign cmd_col_o           = s1_wx_q - 1'b1;
  assign cmd_edge_o.last_row = (s1_wy_q == WW'(WINDOW_SIZE - 1));
  assign cmd_edge_o.last_col = (s1_wx_q == WW'(WINDOW_SIZE - 1));

endmodule

// ===== rtl/core/bu4c_back.sv =====
module bu4c_back #(
  parameter int unsigned WINDOW_SIZE = 128,
  parameter int unsigned SCALE       = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  bu4c_pkg::corners_t                 cmd_corners_i,
  input  logic [$clog2(WINDOW_SIZE)-1:0]     cmd_row_i,
  input  logic [$clog2(WINDOW_SIZE)-1:0]     cmd_col_i,
  input  bu4c_pkg::edge_t                    cmd_edge_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bu4c_pkg::PIX_W-1:0]         out_value_o,
  output logic [bu4c_pkg::COORD_W-1:0]       out_row_o,
  output logic [bu4c_pkg::COORD_W-1:0]       out_col_o,
  output logic                               out_last_o,
  output logic                               out_frame_o
);

  localparam int unsigned FW    = $clog2(2 * SCALE);
  localparam int unsigned VW    = $clog2(SCALE + 1);
  localparam int unsigned S2    = SCALE * SCALE;
  localparam int unsigned KW    = $clog2(S2 + 1);
  localparam int unsigned SUMW  = $clog2(255 * S2 + S2 / 2 + 1);
  localparam int unsigned SH    = SUMW + $clog2(S2) + 1;
  localparam int unsigned RECIP = ((2 ** SH) + S2 - 1) / S2;
  localparam int unsigned PRW   = SUMW + SH;
  localparam int unsigned OW    = $clog2(SCALE * WINDOW_SIZE);
  localparam int unsigned CW    = (OW > bu4c_pkg::COORD_W) ? OW : bu4c_pkg::COORD_W;

  logic [FW-1:0] fy_q, fx_q, fy_end, fx_end;
  logic          at_fx_end, at_fy_end, adv;
  logic [VW-1:0] v, u, iv, iu;
  logic [CW-1:0] r, c;
  logic          p1_en, p2_en, p3_en;

  logic                 p1_vld_q;
  logic [KW-1:0]        p1_wa_q, p1_wb_q, p1_wc_q, p1_wd_q;
  bu4c_pkg::corners_t   p1_px_q;
  logic [CW-1:0]        p1_r_q, p1_c_q;
  logic                 p1_last_q, p1_frame_q;

  logic                 p2_vld_q;
  logic [SUMW-1:0]      p2_sum_q;
  logic [CW-1:0]        p2_r_q, p2_c_q;
  logic                 p2_last_q, p2_frame_q;

  logic                 o_vld_q;
  logic [PRW-1:0]       prod;

  // Stall chain: each stage loads when the one after it can take its content.
  assign p3_en = !o_vld_q || out_ready_i;
  assign p2_en = !p2_vld_q || p3_en;
  assign p1_en = !p1_vld_q || p2_en;

  // Offset iterator over the cell; edge cells run on to twice the scale.
  assign fy_end    = cmd_edge_i.last_row ? FW'(2 * SCALE - 1) : FW'(SCALE - 1);
  assign fx_end    = cmd_edge_i.last_col ? FW'(2 * SCALE - 1) : FW'(SCALE - 1);
  assign at_fx_end = (fx_q == fx_end);
  assign at_fy_end = (fy_q == fy_end);
  assign adv       = cmd_valid_i && p1_en;
  assign cmd_ready_o = p1_en && at_fx_end && at_fy_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fy_q <= '0;
      fx_q <= '0;
    end else if (adv) begin
      if (at_fx_end) begin
        fx_q <= '0;
        fy_q <= at_fy_end ? '0 : fy_q + 1'b1;
      end else begin
        fx_q <= fx_q + 1'b1;
      end
    end
  end

  // Offsets past the scale copy the last window row or column.
  always_comb begin
    v  = (fy_q >= FW'(SCALE)) ? VW'(SCALE) : VW'(fy_q);
    u  = (fx_q >= FW'(SCALE)) ? VW'(SCALE) : VW'(fx_q);
    iv = VW'(SCALE) - v;
    iu = VW'(SCALE) - u;
    r  = CW'(SCALE) * CW'(cmd_row_i) + CW'(fy_q);
    c  = CW'(SCALE) * CW'(cmd_col_i) + CW'(fx_q);
  end

  // First stage: corner weights and output coordinates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (p1_en) begin
      p1_vld_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_wa_q    <= KW'(iv) * KW'(iu);
      p1_wb_q    <= KW'(iv) * KW'(u);
      p1_wc_q    <= KW'(v) * KW'(iu);
      p1_wd_q    <= KW'(v) * KW'(u);
      p1_px_q    <= cmd_corners_i;
      p1_r_q     <= r;
      p1_c_q     <= c;
      p1_last_q  <= at_fx_end && at_fy_end;
      p1_frame_q <= (r == CW'(SCALE * WINDOW_SIZE - 1)) &&
                    (c == CW'(SCALE * WINDOW_SIZE - 1));
    end
  end

  // Second stage: weighted sum with the rounding half added.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (p2_en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_en && p1_vld_q) begin
      p2_sum_q   <= SUMW'(p1_wa_q) * SUMW'(p1_px_q.a) + SUMW'(p1_wb_q) * SUMW'(p1_px_q.b) +
                    SUMW'(p1_wc_q) * SUMW'(p1_px_q.c) + SUMW'(p1_wd_q) * SUMW'(p1_px_q.d) +
                    SUMW'(S2 / 2);
      p2_r_q     <= p1_r_q;
      p2_c_q     <= p1_c_q;
      p2_last_q  <= p1_last_q;
      p2_frame_q <= p1_frame_q;
    end
  end

  // Divide by the squared scale through a reciprocal; exact over the sum range.
  assign prod = PRW'(p2_sum_q) * PRW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (p3_en) begin
      o_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p3_en && p2_vld_q) begin
      out_value_o <= prod[SH +: bu4c_pkg::PIX_W];
      out_row_o   <= p2_r_q[bu4c_pkg::COORD_W-1:0];
      out_col_o   <= p2_c_q[bu4c_pkg::COORD_W-1:0];
      out_last_o  <= p2_last_q;
      out_frame_o <= p2_frame_q;
    end
  end

  assign out_valid_o = o_vld_q;

endmodule

// ===== rtl/core/bilinear_upscale_4x_crop.sv =====
// Channel   Direction  Handshake                   Contents
// s_axis    in         s_axis_tvalid/tready        source pixel, frame start flag
// m_axis    out        m_axis_tvalid/tready        output pixel, row, column, run and frame end
// cfg       in         cfg_we_i (no back-pressure) register index and write data
//
// Output pixels leave at one per cycle while m_axis_tready is high and cells are queued; a
// cell yields SCALE*SCALE of them (16), and a cell on the last window row or column up to
// 4*SCALE*SCALE (64), set by the back-end offset iterator. Input pixels are taken one per
// cycle while the cell queue has room. A closing pixel passes s1, the cell queue, p1, p2
// and the output register. Reset clears control state; the line buffer is not cleared and
// needs no sweep. Either stream may stall at any time; the cell queue decouples the two sides.
module bilinear_upscale_4x_crop #(
  parameter int unsigned WINDOW_SIZE      = 128,
  parameter int unsigned SCALE            = 4,
  parameter int unsigned MAX_SOURCE_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bu4c_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bu4c_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bu4c_pkg::PIX_W-1:0]        s_axis_tdata,   // pixel_value
  input  logic                              s_axis_tuser,   // frame_start
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bu4c_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // out_value, out_row, out_col
  output logic                              m_axis_tlast,   // run_end
  output logic                              m_axis_tuser    // frame_done
);

  localparam int unsigned WW   = $clog2(WINDOW_SIZE);
  localparam int unsigned QW   = $bits(bu4c_pkg::corners_t) + 2 * WW + $bits(bu4c_pkg::edge_t);
  localparam int unsigned PADW = bu4c_pkg::OUT_DATA_W - bu4c_pkg::PIX_W - 2 * bu4c_pkg::COORD_W;

  logic                             cmd_valid, cmd_ready;
  bu4c_pkg::corners_t               cmd_corners, hd_corners;
  logic [WW-1:0]                    cmd_row, cmd_col, hd_row, hd_col;
  bu4c_pkg::edge_t                  cmd_edge, hd_edge;
  logic [QW-1:0]                    q_wdata, q_rdata;
  logic                             hd_valid, hd_ready;
  logic [bu4c_pkg::PIX_W-1:0]       out_value;
  logic [bu4c_pkg::COORD_W-1:0]     out_row, out_col;

  bu4c_front #(
    .WINDOW_SIZE      (WINDOW_SIZE),
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pix_valid_i   (s_axis_tvalid),
    .pix_ready_o   (s_axis_tready),
    .pix_value_i   (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_corners_o (cmd_corners),
    .cmd_row_o     (cmd_row),
    .cmd_col_o     (cmd_col),
    .cmd_edge_o    (cmd_edge)
  );

  // Cell queue between classification and interpolation.
  assign q_wdata = {cmd_corners, cmd_row, cmd_col, cmd_edge};
  assign {hd_corners, hd_row, hd_col, hd_edge} = q_rdata;

  bu4c_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wvalid_i (cmd_valid),
    .wready_o (cmd_ready),
    .wdata_i  (q_wdata),
    .rvalid_o (hd_valid),
    .rready_i (hd_ready),
    .rdata_o  (q_rdata)
  );

  bu4c_back #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SCALE       (SCALE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (hd_valid),
    .cmd_ready_o   (hd_ready),
    .cmd_corners_i (hd_corners),
    .cmd_row_i     (hd_row),
    .cmd_col_i     (hd_col),
    .cmd_edge_i    (hd_edge),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_value_o   (out_value),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_last_o    (m_axis_tlast),
    .out_frame_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {{PADW{1'b0}}, out_col, out_row, out_value};

endmodule

// ===== test/tb_bilinear_upscale_4x_crop.sv =====
module tb_bilinear_upscale_4x_crop;

  localparam int unsigned PIX_W       = bu4c_pkg::PIX_W;
  localparam int unsigned COORD_W     = bu4c_pkg::COORD_W;
  localparam int unsigned OUT_DATA_W  = bu4c_pkg::OUT_DATA_W;
  localparam int unsigned CFG_IDX_W   = bu4c_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W  = bu4c_pkg::CFG_DATA_W;
  localparam int unsigned SRC_WIDTH_W = bu4c_pkg::SRC_WIDTH_W;
  localparam int unsigned WIN_POS_W   = bu4c_pkg::WIN_POS_W;

  localparam int unsigned WIN       = 128;
  localparam int unsigned ZOOM      = 4;
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned LAST_OUT  = ZOOM * WIN - 1;
  localparam int unsigned PAD_W     = OUT_DATA_W - PIX_W - 2 * COORD_W;
  // Cycles allowed after the last result for a request still in the pipe.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned MAX_REPORTS   = 10;

  // One upscaled output pixel as the block reports it.
  typedef struct packed {
    logic               frame_done;
    logic               run_end;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   value;
  } upscaled_px_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata  = '0;  // pixel_value
  logic                  s_axis_tuser  = 1'b0;  // frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // out_value, out_row, out_col
  logic                  m_axis_tlast;  // run_end
  logic                  m_axis_tuser;  // frame_done

  // When set, neither side inserts idle cycles.
  bit          calm       = 1'b0;
  int unsigned fail_count = 0;

  // Predictor state and its copy of the registers.
  upscaled_px_t           expected_px_q[$];
  logic [PIX_W-1:0]       line_buf[WIN];
  logic [PIX_W-1:0]       left_px       = '0;
  logic [PIX_W-1:0]       upper_left_px = '0;
  int unsigned            src_x         = 0;
  int unsigned            src_y         = 0;
  logic [SRC_WIDTH_W-1:0] cfg_src_width = bu4c_pkg::RESET_SOURCE_WIDTH;
  logic [WIN_POS_W-1:0]   cfg_win_top   = '0;
  logic [WIN_POS_W-1:0]   cfg_win_left  = '0;

  bilinear_upscale_4x_crop dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock, period 4.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Weighted sum of the four cell corners, rounded to nearest with halves up.
  function automatic logic [PIX_W-1:0] bilinear_mix(input int unsigned a, input int unsigned b,
                                                    input int unsigned c, input int unsigned d,
                                                    input int unsigned v, input int unsigned u);
    int unsigned sum;
    sum = (ZOOM - v) * (ZOOM - u) * a + (ZOOM - v) * u * b
        + v * (ZOOM - u) * c + v * u * d;
    return PIX_W'((sum + (ZOOM * ZOOM) / 2) / (ZOOM * ZOOM));
  endfunction

  // Advance the predictor by one accepted source pixel and queue the output pixels it yields.
  function automatic void predict_upscale(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned  wy, wx, above, nrows, ncols, r0, c0, r, c, v, u, w;
    upscaled_px_t px;
    if (fs) begin
      src_x = 0;
      src_y = 0;
    end
    if (src_y >= cfg_win_top && src_x >= cfg_win_left) begin
      wy = src_y - cfg_win_top;
      wx = src_x - cfg_win_left;
      if (wy < WIN && wx < WIN) begin
        above = line_buf[wx];
        if (wy > 0 && wx > 0) begin
          // The last window row and column run on past the cell to copy the edge.
          nrows = (wy == WIN - 1) ? 2 * ZOOM : ZOOM;
          ncols = (wx == WIN - 1) ? 2 * ZOOM : ZOOM;
          r0 = ZOOM * (wy - 1);
          c0 = ZOOM * (wx - 1);
          for (int unsigned fy = 0; fy < nrows; fy++) begin
            v = (fy < ZOOM) ? fy : ZOOM;
            for (int unsigned fx = 0; fx < ncols; fx++) begin
              u = (fx < ZOOM) ? fx : ZOOM;
              r = r0 + fy;
              c = c0 + fx;
              px.value      = bilinear_mix(upper_left_px, above, left_px, pix, v, u);
              px.row        = COORD_W'(r);
              px.col        = COORD_W'(c);
              px.run_end    = (fy == nrows - 1) && (fx == ncols - 1);
              px.frame_done = (r == LAST_OUT) && (c == LAST_OUT);
              expected_px_q.push_back(px);
            end
          end
        end
        upper_left_px = PIX_W'(above);
        left_px       = pix;
        line_buf[wx]  = pix;
      end
    end
    // Row length is clamped to the range the block supports.
    w = cfg_src_width;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (w == 0) w = 1;
    src_x++;
    if (src_x >= w) begin
      src_x = 0;
      src_y = (src_y + 1) % 1024;
    end
  endfunction

  // Output side: random back-pressure, with tready held low about 8 percent of the time.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 8);
  end

  // Compare every accepted output request with the oldest expected pixel.
  always @(posedge clk_i) begin : check_results
    upscaled_px_t          want;
    logic [OUT_DATA_W-1:0] want_data;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_px_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected output pixel: data %h last %b user %b",
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want      = expected_px_q.pop_front();
        want_data = {{PAD_W{1'b0}}, want.col, want.row, want.value};
        if (m_axis_tdata !== want_data || m_axis_tlast !== want.run_end ||
            m_axis_tuser !== want.frame_done) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("output mismatch: expected value %0d row %0d col %0d last %b done %b, %s",
                     want.value, want.row, want.col, want.run_end, want.frame_done,
                     $sformatf("got value %0d row %0d col %0d last %b done %b",
                               m_axis_tdata[PIX_W-1:0], m_axis_tdata[PIX_W+COORD_W-1:PIX_W],
                               m_axis_tdata[PIX_W+2*COORD_W-1:PIX_W+COORD_W],
                               m_axis_tlast, m_axis_tuser));
        end
      end
    end
  end

  // Send one source pixel, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_upscale(pix, fs);
  endtask

  // Pixel values with the extremes made more likely.
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Send count random pixels; the first one optionally starts a frame.
  task automatic send_random_pixels(input int unsigned count, input bit start_frame);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(random_pixel(), start_frame && i == 0);
  endtask

  // Stop sending and wait until every expected pixel has arrived and the pipe is empty.
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_px_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive cycles; the block must be idle.
  task automatic set_window(input int unsigned width, input int unsigned top,
                            input int unsigned left);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bu4c_pkg::CFG_SOURCE_WIDTH;
    cfg_data_i <= CFG_DATA_W'(width);
    @(posedge clk_i);
    cfg_idx_i  <= bu4c_pkg::CFG_WINDOW_TOP;
    cfg_data_i <= CFG_DATA_W'(top);
    @(posedge clk_i);
    cfg_idx_i  <= bu4c_pkg::CFG_WINDOW_LEFT;
    cfg_data_i <= CFG_DATA_W'(left);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_src_width = SRC_WIDTH_W'(width);
    cfg_win_top   = WIN_POS_W'(top);
    cfg_win_left  = WIN_POS_W'(left);
  endtask

  // A 2x2 frame on a two-pixel-wide source yields exactly one cell.
  task automatic send_cell(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                           input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d);
    send_pixel(a, 1'b1);
    send_pixel(b, 1'b0);
    send_pixel(c, 1'b0);
    send_pixel(d, 1'b0);
  endtask

  // Registers at their reset values: the start of the first row fills the line buffer
  // and yields no output.
  task automatic test_reset_defaults();
    send_random_pixels(12, 1'b1);
    wait_until_drained();
  endtask

  // Corner values at both extremes.
  task automatic test_pixel_extremes();
    set_window(2, 0, 0);
    send_cell('0, '0, '0, '0);
    send_cell('1, '1, '1, '1);
    send_cell('0, '1, '1, '0);
    send_cell('1, '0, '0, '1);
    wait_until_drained();
  endtask

  // A frame start in the middle of a row restarts at the source origin.
  task automatic test_frame_restart();
    set_window(3, 0, 0);
    send_random_pixels(4, 1'b1);
    send_random_pixels(6, 1'b1);
    wait_until_drained();
  endtask

  // Offset window, then a window that lies entirely outside the source.
  task automatic test_window_offset();
    set_window(4, 1, 2);
    send_random_pixels(12, 1'b1);
    wait_until_drained();
    set_window(4, 1023, 1023);
    send_random_pixels(8, 1'b1);
    wait_until_drained();
  endtask

  // A zero row length acts as one: every pixel moves to the next row.
  task automatic test_narrow_rows();
    set_window(0, 5, 0);
    send_random_pixels(5, 1'b1);
    wait_until_drained();
    set_window(2, 5, 0);
    send_random_pixels(4, 1'b0);
    wait_until_drained();
  endtask

  // Short frames on narrow sources with random windows, stray frame starts and stalls.
  task automatic test_random_frames();
    int unsigned sent, seg, width, count;
    sent = 0;
    seg  = 0;
    while (sent < 32) begin
      wait_until_drained();
      if ($urandom_range(9) == 0) width = $urandom_range(1, 12);
      else width = $urandom_range(2, 6);
      set_window(width, $urandom_range(0, 2), $urandom_range(0, 2));
      count = width * $urandom_range(3, 6);
      for (int unsigned i = 0; i < count; i++) begin
        // Once, hold the sender back until the output side has caught up.
        if (seg == 0 && i == count / 2) wait_until_drained();
        send_pixel(random_pixel(), i == 0 || $urandom_range(99) < 3);
      end
      sent += count;
      seg++;
    end
    wait_until_drained();
  endtask

  // One-pixel rows walk down to the last window row, whose cell copies the bottom edge.
  task automatic test_last_row();
    set_window(1, 0, 0);
    for (int unsigned i = 0; i < WIN - 1; i++) begin
      calm = (i >= WIN / 4);
      send_pixel(random_pixel(), i == 0);
    end
    calm = 1'b0;
    wait_until_drained();
    set_window(2, 0, 0);
    send_random_pixels(2, 1'b0);
    wait_until_drained();
  endtask

  // Reset once, then run every test in turn.
  initial begin
    foreach (line_buf[i]) line_buf[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_pixel_extremes();
    test_frame_restart();
    test_window_offset();
    test_narrow_rows();
    test_random_frames();
    test_last_row();
    wait_until_drained();
    if (fail_count == 0 && expected_px_q.size() == 0) begin
      $display("bilinear_upscale_4x_crop regression: pass");
    end else begin
      $display("bilinear_upscale_4x_crop regression: fail");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("bilinear_upscale_4x_crop regression: fail");
    $finish;
  end

endmodule
